### rtl/assert_macros.svh
// Assertion macros used by sm3_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SM3_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sm3 check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define SM3_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sm3 check failed: next-cycle implication");

`endif

### rtl/sm3_pkg.sv
// Shared types, constants and functions of the SM3 hash engine.
// No dependencies.
package sm3_pkg;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;

    localparam logic [31:0] SM3_IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    // Source of the byte written into the block buffer
    typedef enum logic [1:0] {
        BSRC_MSG   = 2'd0,
        BSRC_PAD80 = 2'd1,
        BSRC_ZERO  = 2'd2,
        BSRC_LEN   = 2'd3
    } byte_src_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       put;        // write one byte into the block
        byte_src_t  src;
        logic [1:0] lane;       // byte lane within the word, 0 is MSB
        logic [2:0] len_idx;    // length byte, 0 is MSB
        logic       add_len;    // count 8 more message bits
        logic       init_work;  // load A..H from the chaining value
        logic       round;      // run one compression round
        logic [5:0] round_idx;
        logic       fold;       // chaining value ^= A..H
        logic       clear;      // back to IV, length zero
        logic [2:0] out_idx;    // digest word on the output
    } cmd_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl32(x, 9) ^ rotl32(x, 17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl32(x, 15) ^ rotl32(x, 23);
    endfunction

    // Round constant already rotated by the round number
    function automatic logic [31:0] round_const(input logic [5:0] j);
        logic [31:0] t;
        logic [63:0] dbl;
        t   = (j < 6'd16) ? T_LOW : T_HIGH;
        dbl = {t, t} << j[4:0];
        return dbl[63:32];
    endfunction

endpackage

### rtl/sm3_ctrl.sv
// Sequencer of the SM3 engine: byte intake, padding, rounds, digest output.
// Depends on sm3_pkg.
module sm3_ctrl
    import sm3_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_word_index,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_PADLEN,
        S_ROUND,
        S_FOLD,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [5:0] pos_reg, pos_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] oidx_reg, oidx_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        logic   do_put;
        state_t after;
        do_put       = 1'b0;
        after        = state_reg;
        state_next   = state_reg;
        ret_next     = ret_reg;
        pos_next     = pos_reg;
        rnd_next     = rnd_reg;
        oidx_next    = oidx_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        cmd           = '0;
        cmd.lane      = pos_reg[1:0];
        cmd.len_idx   = pos_reg[2:0];
        cmd.round_idx = rnd_reg;
        cmd.out_idx   = oidx_reg;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    do_put      = 1'b1;
                    cmd.src     = BSRC_MSG;
                    cmd.add_len = 1'b1;
                    after       = s_last_byte ? S_PAD80 : S_IDLE;
                end
            end
            S_PAD80: begin
                do_put  = 1'b1;
                cmd.src = BSRC_PAD80;
                after   = S_PADZ;
            end
            S_PADZ: begin
                do_put = 1'b1;
                if (pos_reg == 6'd56) begin
                    cmd.src = BSRC_LEN;
                    after   = S_PADLEN;
                end else begin
                    cmd.src = BSRC_ZERO;
                    after   = S_PADZ;
                end
            end
            S_PADLEN: begin
                do_put  = 1'b1;
                cmd.src = BSRC_LEN;
                after   = (pos_reg == 6'd63) ? S_OUT : S_PADLEN;
            end
            S_ROUND: begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                cmd.fold   = 1'b1;
                state_next = ret_reg;
                if (ret_reg == S_OUT) begin
                    m_valid_next = 1'b1;
                    oidx_next    = 3'd0;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        cmd.clear    = 1'b1;
                        m_valid_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Block full: compress before going on
        if (do_put) begin
            cmd.put  = 1'b1;
            pos_next = pos_reg + 6'd1;
            if (pos_reg == 6'd63) begin
                cmd.init_work = 1'b1;
                state_next    = S_ROUND;
                ret_next      = after;
                rnd_next      = 6'd0;
            end else begin
                state_next = after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            pos_reg     <= '0;
            rnd_reg     <= '0;
            oidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            pos_reg     <= pos_next;
            rnd_reg     <= rnd_next;
            oidx_reg    <= oidx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_word_index = oidx_reg;

endmodule

### rtl/sm3_datapath.sv
// SM3 datapath: byte packing, schedule window, round logic, chaining value.
// Depends on sm3_pkg.
module sm3_datapath
    import sm3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    input  logic [7:0]  s_msg_byte,
    output logic [31:0] m_digest_word
);

    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] win_reg [16];      // win_reg[0] is the oldest word
    logic [31:0] win_next [16];
    logic [31:0] part_reg, part_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next, f_next, g_next, h_next;

    logic [7:0]  byte_val;
    logic [2:0]  len_sel;
    logic [31:0] exp_word;
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;

    always_comb begin
        len_sel = 3'(3'd7 - cmd.len_idx);
        case (cmd.src)
            BSRC_MSG:   byte_val = s_msg_byte;
            BSRC_PAD80: byte_val = 8'h80;
            BSRC_ZERO:  byte_val = 8'h00;
            BSRC_LEN:   byte_val = len_reg[{len_sel, 3'b000} +: 8];
            default:    byte_val = 8'h00;
        endcase
    end

    // Round function
    always_comb begin
        exp_word = perm1(win_reg[0] ^ win_reg[7] ^ rotl32(win_reg[13], 15))
                 ^ rotl32(win_reg[3], 7) ^ win_reg[10];
        a12 = rotl32(a_reg, 12);
        ss1 = rotl32(a12 + e_reg + round_const(cmd.round_idx), 7);
        ss2 = ss1 ^ a12;
        if (cmd.round_idx[5:4] == 2'b00) begin
            ff = a_reg ^ b_reg ^ c_reg;
            gg = e_reg ^ f_reg ^ g_reg;
        end else begin
            ff = (a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg);
            gg = (e_reg & f_reg) | (~e_reg & g_reg);
        end
        tt1 = ff + d_reg + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + h_reg + ss1 + win_reg[0];
    end

    always_comb begin
        chain_next = chain_reg;
        win_next   = win_reg;
        part_next  = part_reg;
        len_next   = len_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        e_next = e_reg; f_next = f_reg; g_next = g_reg; h_next = h_reg;

        if (cmd.add_len) begin
            len_next = len_reg + 64'd8;
        end

        // First byte of a word overwrites the whole word
        if (cmd.put) begin
            case (cmd.lane)
                2'd0: part_next = {byte_val, 24'h0};
                2'd1: part_next = {part_reg[31:24], byte_val, 16'h0};
                2'd2: part_next = {part_reg[31:16], byte_val, 8'h0};
                2'd3: begin
                    for (int i = 0; i < 15; i++) begin
                        win_next[i] = win_reg[i + 1];
                    end
                    win_next[15] = {part_reg[31:8], byte_val};
                end
                default: part_next = part_reg;
            endcase
        end

        if (cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = exp_word;
            a_next = tt1;
            b_next = a_reg;
            c_next = rotl32(b_reg, 9);
            d_next = c_reg;
            e_next = perm0(tt2);
            f_next = e_reg;
            g_next = rotl32(f_reg, 19);
            h_next = g_reg;
        end

        if (cmd.init_work) begin
            a_next = chain_reg[0]; b_next = chain_reg[1];
            c_next = chain_reg[2]; d_next = chain_reg[3];
            e_next = chain_reg[4]; f_next = chain_reg[5];
            g_next = chain_reg[6]; h_next = chain_reg[7];
        end

        if (cmd.fold) begin
            chain_next[0] = chain_reg[0] ^ a_reg;
            chain_next[1] = chain_reg[1] ^ b_reg;
            chain_next[2] = chain_reg[2] ^ c_reg;
            chain_next[3] = chain_reg[3] ^ d_reg;
            chain_next[4] = chain_reg[4] ^ e_reg;
            chain_next[5] = chain_reg[5] ^ f_reg;
            chain_next[6] = chain_reg[6] ^ g_reg;
            chain_next[7] = chain_reg[7] ^ h_reg;
        end

        if (cmd.clear) begin
            chain_next = SM3_IV;
            len_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= SM3_IV;
            len_reg   <= '0;
        end else begin
            chain_reg <= chain_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        part_reg <= part_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
        e_reg <= e_next; f_reg <= f_next; g_reg <= g_next; h_reg <= h_next;
    end

    assign m_digest_word = chain_reg[cmd.out_idx];

endmodule

### rtl/sm3_hash_engine_top.sv
// SM3 hash engine top level: controller plus datapath. Depends on sm3_pkg.
// Throughput: one byte item per cycle while s_ready is high; the 64th byte of a block
// starts the compression rounds and a fold (one round per cycle through the shared round unit).
// Last byte: padding bytes go in one per cycle (9 to 72), plus the rounds and fold of each block.
// Digest: eight result items, one per cycle while m_ready is high.
// Reset: synchronous, active-low aresetn; chaining value back to IV, length to zero.
module sm3_hash_engine_top
    import sm3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_msg_byte,
    input  logic        s_last_byte,
    // digest output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    // Command bundle from the sequencer to the datapath
    cmd_t cmd;

    // Sequencer: takes items only when idle, steps padding bytes,
    // counts the 64 rounds and the eight digest words.
    sm3_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_index (m_word_index),
        .cmd          (cmd)
    );

    // Datapath: packs bytes big-endian into words, keeps the 16-word
    // schedule window (expanded one word per round), A..H and the
    // chaining value. The digest word is read straight from the chain.
    sm3_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_msg_byte    (s_msg_byte),
        .m_digest_word (m_digest_word)
    );

    // Final digest word marker
    assign m_last_word = (m_word_index == 3'd7);

endmodule

### rtl/sm3_checker.sv
// Port-level checks of the SM3 engine, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module sm3_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_last_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_word_index,
    input logic       m_last_word
);

    // No intake while a digest is being handed out
    `SM3_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready)

    // Digest words go out in order, one index step per handoff
    `SM3_ASSERT_NXT(a_index_step, aclk, aresetn, m_valid && m_ready && !m_last_word, m_valid && (m_word_index == 3'($past(m_word_index) + 3'd1)))

    // Digest ends after the eighth word
    `SM3_ASSERT_NXT(a_digest_end, aclk, aresetn, m_valid && m_ready && m_last_word, !m_valid)

    // Padding takes time: no digest right after the last byte
    `SM3_ASSERT_NXT(a_pad_delay, aclk, aresetn, s_valid && s_ready && s_last_byte, !m_valid)

endmodule

bind sm3_hash_engine_top sm3_checker u_sm3_checker (.*);
